/* hdl/pulse_width_remote_code_receiver_top_macros.svh */
// assertion macros used by the checker file
`ifndef PULSE_WIDTH_REMOTE_CODE_RECEIVER_TOP_MACROS_SVH
`define PULSE_WIDTH_REMOTE_CODE_RECEIVER_TOP_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define PWRC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet while reset is held
`define PWRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/pwrc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package pwrc_pkg;

  localparam int TS_W        = 16;
  localparam int CODE_W      = 8;
  localparam int CNT_W       = 4;
  localparam int PHASE_W     = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_LOW_MIN        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_LOW_MAX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_ERROR_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_HIGH_MIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_HIGH_MIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_HIGH_MIN   = 3'd5;

  // reset values of the timing registers, in timer ticks
  localparam logic [TS_W-1:0] RST_LOW_MIN        = 16'd100;
  localparam logic [TS_W-1:0] RST_FIRST_LOW_MAX  = 16'd20000;
  localparam logic [TS_W-1:0] RST_HIGH_ERROR_MIN = 16'd60000;
  localparam logic [TS_W-1:0] RST_SYNC_HIGH_MIN  = 16'd8000;
  localparam logic [TS_W-1:0] RST_ZERO_HIGH_MIN  = 16'd1500;
  localparam logic [TS_W-1:0] RST_ONE_HIGH_MIN   = 16'd300;

  localparam logic [CNT_W-1:0] BITS_PER_BYTE = 4'd8;

  // result item, code_valid in the lowest bit
  typedef struct packed {
    logic              sync_found;
    logic              frame_error;
    logic [CODE_W-1:0] code_byte;
    logic              code_valid;
  } pwrc_result_t;

  localparam int RES_W      = $bits(pwrc_result_t);
  localparam int OUT_PAD_W  = OUT_TDATA_W - RES_W;
  localparam int IN_PAD_W   = IN_TDATA_W - 1 - TS_W;

endpackage
`default_nettype wire

/* hdl/pulse_width_remote_code_receiver_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// a result is registered in out_r, or in the skid register while out_r is stalled
// throughput: one edge request per clock while the skid is empty; a two-deep output
//   stage (result plus skid register) keeps in_tready high while one result stalls
// reset: synchronous, active low; clears decoder state, empties the output stage
//   and loads the timing registers with their default tick counts
module pulse_width_remote_code_receiver_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // edge requests
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // [0] edge_level, [16:1] timestamp, [23:17] zero
  input  wire logic [pwrc_pkg::IN_TDATA_W-1:0] in_tdata,
  // decode results
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [0] code_valid, [8:1] code_byte, [9] frame_error, [10] sync_found, [15:11] zero
  output logic [pwrc_pkg::OUT_TDATA_W-1:0]     out_tdata,
  // timing register writes
  input  wire logic                            cfg_wr_en,
  input  wire logic [pwrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pwrc_pkg::TS_W-1:0]       cfg_data
);
  import pwrc_pkg::*;

  // decoder phases
  localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
  localparam logic [PHASE_W-1:0] PH_LOW  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_HIGH = 2'd2;
  localparam logic [PHASE_W-1:0] PH_SYNC = 2'd3;

  // timing registers
  logic [TS_W-1:0] low_min_r, first_low_max_r, high_error_min_r;
  logic [TS_W-1:0] sync_high_min_r, zero_high_min_r, one_high_min_r;

  // decoder state
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic               first_high_r, first_high_nxt;
  logic [TS_W-1:0]    low_start_r, low_start_nxt;
  logic [TS_W-1:0]    high_start_r, high_start_nxt;
  logic [CODE_W-1:0]  shift_byte_r, shift_byte_nxt;
  logic [CNT_W-1:0]   bit_count_r, bit_count_nxt;
  logic [CODE_W-1:0]  first_frame_r, first_frame_nxt;

  // output stage
  logic         out_v_r, skid_v_r;
  pwrc_result_t out_r, skid_r;
  pwrc_result_t res;

  logic              accept;
  logic              out_free;
  logic              edge_level;
  logic [TS_W-1:0]   ts;
  logic [TS_W-1:0]   low_width, high_width;
  logic              clr;
  logic              got_bit;
  logic [CODE_W-1:0] new_byte;
  logic [CNT_W-1:0]  new_count;

  assign edge_level = in_tdata[0];
  assign ts         = in_tdata[TS_W:1];

  // widths wrap modulo the timer period
  assign low_width  = ts - low_start_r;
  assign high_width = ts - high_start_r;

  // skid register full means the next result would have nowhere to go
  assign in_tready  = !skid_v_r;
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_v_r || out_tready;
  assign out_tvalid = out_v_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_r};

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_min_r        <= RST_LOW_MIN;
      first_low_max_r  <= RST_FIRST_LOW_MAX;
      high_error_min_r <= RST_HIGH_ERROR_MIN;
      sync_high_min_r  <= RST_SYNC_HIGH_MIN;
      zero_high_min_r  <= RST_ZERO_HIGH_MIN;
      one_high_min_r   <= RST_ONE_HIGH_MIN;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LOW_MIN:        low_min_r        <= cfg_data;
        REG_FIRST_LOW_MAX:  first_low_max_r  <= cfg_data;
        REG_HIGH_ERROR_MIN: high_error_min_r <= cfg_data;
        REG_SYNC_HIGH_MIN:  sync_high_min_r  <= cfg_data;
        REG_ZERO_HIGH_MIN:  zero_high_min_r  <= cfg_data;
        REG_ONE_HIGH_MIN:   one_high_min_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // edge decode: one pass of compares from the current state
  always_comb begin
    phase_nxt       = phase_r;
    first_high_nxt  = first_high_r;
    low_start_nxt   = low_start_r;
    high_start_nxt  = high_start_r;
    shift_byte_nxt  = shift_byte_r;
    bit_count_nxt   = bit_count_r;
    first_frame_nxt = first_frame_r;
    res             = '0;
    clr             = 1'b0;
    got_bit         = 1'b0;
    new_byte        = shift_byte_r;
    // count saturates at a full byte
    new_count       = (bit_count_r < BITS_PER_BYTE) ? bit_count_r + 4'd1 : bit_count_r;

    if (edge_level) begin
      // rising edge ends a low pulse
      if (low_width < low_min_r) begin
        clr             = 1'b1;
        res.frame_error = 1'b1;
      end else if (!first_high_r && (low_width > first_low_max_r)) begin
        clr             = 1'b1;
        res.frame_error = 1'b1;
      end else begin
        if (!first_high_r) begin
          first_high_nxt = 1'b1;
          phase_nxt      = PH_HIGH;
        end
        high_start_nxt = ts;
      end
    end else begin
      // falling edge ends a high pulse
      low_start_nxt = ts;
      if (phase_r == PH_IDLE) begin
        phase_nxt = PH_LOW;
      end else if (((phase_r == PH_HIGH) || (phase_r == PH_SYNC)) && first_high_r) begin
        if (high_width >= high_error_min_r) begin
          clr             = 1'b1;
          res.frame_error = 1'b1;
        end else if (high_width >= sync_high_min_r) begin
          shift_byte_nxt = '0;
          bit_count_nxt  = '0;
          phase_nxt      = PH_SYNC;
          res.sync_found = 1'b1;
        end else if (phase_r == PH_SYNC) begin
          if (high_width >= zero_high_min_r) begin
            got_bit  = 1'b1;
            new_byte = {1'b0, shift_byte_r[CODE_W-1:1]};
          end else if (high_width >= one_high_min_r) begin
            got_bit  = 1'b1;
            new_byte = {1'b1, shift_byte_r[CODE_W-1:1]};
          end else begin
            clr             = 1'b1;
            res.frame_error = 1'b1;
          end
        end
      end
    end

    if (got_bit) begin
      shift_byte_nxt = new_byte;
      bit_count_nxt  = new_count;
      if (new_count >= BITS_PER_BYTE) begin
        // a byte counts once two successive frames agree
        if (first_frame_r == '0) begin
          first_frame_nxt = new_byte;
        end else if (new_byte == first_frame_r) begin
          res.code_valid = 1'b1;
          res.code_byte  = new_byte;
          clr            = 1'b1;
        end else begin
          first_frame_nxt = new_byte;
        end
      end
    end

    // error or confirmed byte: back to a clean receiver
    if (clr) begin
      phase_nxt       = PH_IDLE;
      first_high_nxt  = 1'b0;
      low_start_nxt   = '0;
      high_start_nxt  = '0;
      shift_byte_nxt  = '0;
      bit_count_nxt   = '0;
      first_frame_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      first_high_r  <= 1'b0;
      low_start_r   <= '0;
      high_start_r  <= '0;
      shift_byte_r  <= '0;
      bit_count_r   <= '0;
      first_frame_r <= '0;
    end else if (accept) begin
      phase_r       <= phase_nxt;
      first_high_r  <= first_high_nxt;
      low_start_r   <= low_start_nxt;
      high_start_r  <= high_start_nxt;
      shift_byte_r  <= shift_byte_nxt;
      bit_count_r   <= bit_count_nxt;
      first_frame_r <= first_frame_nxt;
    end
  end

  // output register with skid: the skid holds a result made while the
  // output register was stalled, and drains first
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_free) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= accept;
      end
    end else if (accept) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_v_r) begin
        out_r <= skid_r;
      end else if (accept) begin
        out_r <= res;
      end
    end else if (accept) begin
      skid_r <= res;
    end
  end

endmodule
`default_nettype wire

/* hdl/pwrc_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "pulse_width_remote_code_receiver_top_macros.svh"
module pwrc_assert_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [pwrc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import pwrc_pkg::*;

  pwrc_result_t res;
  logic [OUT_PAD_W-1:0] pad;

  assign res = out_tdata[RES_W-1:0];
  assign pad = out_tdata[OUT_TDATA_W-1:RES_W];

  // a confirmed byte is never zero and never comes with an error or a sync
  `PWRC_ASSERT_IMPL(a_code_clean, out_tvalid && res.code_valid, (res.code_byte != '0) && !res.frame_error && !res.sync_found, "confirmed byte with bad flags")

  // no byte shown without code_valid, and unused bits stay zero
  `PWRC_ASSERT_IMPL(a_code_zero, out_tvalid && !res.code_valid, (res.code_byte == '0) && (pad == '0), "stray code bits")

  // one edge cannot both end a sync pulse and break timing
  `PWRC_ASSERT_IMPL(a_err_sync, out_tvalid, !(res.frame_error && res.sync_found), "error and sync together")

  // a stalled result holds
  `PWRC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

endmodule

bind pulse_width_remote_code_receiver_top pwrc_assert_checker u_pwrc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
